// ===== rtl/ordered_list_append_find_remove_defines.svh =====
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_APPEND_FIND_REMOVE_DEFINES_SVH
`define ORDERED_LIST_APPEND_FIND_REMOVE_DEFINES_SVH

// Clocked check, held off while reset is active.
`define OLAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define OLAFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/olafr_pkg.sv =====
// Shared constants, codes, types and reset functions of the ordered list.
package olafr_pkg;

  // List geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned RESET_FILL = 7;

  // Word field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CNT_OUT_W  = 5;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - POS_W - CNT_OUT_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Request broadcast to every cell
  typedef struct packed {
    logic                     append;
    logic                     remove;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // What one cell holds and hands to its neighbor
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } link_t;

  // Reset contents of cell idx: entry i holds i below the fill mark
  function automatic link_t reset_link(int unsigned idx);
    link_t l;
    l.valid = (idx < RESET_FILL);
    l.data  = (idx < RESET_FILL) ? DATA_W'(idx) : '0;
    return l;
  endfunction

endpackage

// ===== rtl/olafr_cell.sv =====
// One list cell: holds an entry, compares it, and shifts or appends.
module olafr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olafr_pkg::link_t      rst_link_i,   // contents after reset
  input  olafr_pkg::cell_ctrl_t ctrl_i,
  input  logic                  prev_valid_i, // cell toward the head is occupied
  input  logic                  seen_i,       // a match sits nearer the head
  input  olafr_pkg::link_t      next_i,       // cell toward the tail
  output olafr_pkg::link_t      link_o,
  output logic                  seen_o,
  output logic                  first_o
);

  olafr_pkg::link_t link_q, link_d;
  logic             match;

  // Compare and pass the match flag down the chain
  assign match   = link_q.valid && (link_q.data == ctrl_i.value);
  assign first_o = match && !seen_i;
  assign seen_o  = seen_i || match;
  assign link_o  = link_q;

  // Append fills the first free cell; remove pulls from the tail side
  always_comb begin
    link_d = link_q;
    if (ctrl_i.append && prev_valid_i && !link_q.valid) begin
      link_d.valid = 1'b1;
      link_d.data  = ctrl_i.value;
    end else if (ctrl_i.remove && (seen_i || match)) begin
      link_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= rst_link_i;
    end else begin
      link_q <= link_d;
    end
  end

endmodule

// ===== rtl/ordered_list_append_find_remove.sv =====
// Top level of the ordered list: request decode, cell chain and result register.
//
// Bounded ordered list of signed 32-bit entries kept in a row of cells.
// Input channel s_axis: tuser carries the request (append, find, remove),
// tdata the value. Output channel m_axis: tuser carries the status (ok,
// not found, full), tdata the match position and the entry count after
// the request. Every request yields exactly one result word.
// All cells compare their entry with the value in the same cycle; the first
// match is picked along the chain, and on remove each cell from the match
// on takes its tail-side neighbor, so the gap closes in that same cycle.
// The result word is registered, ready in the cycle after its request is
// taken; one request is taken per cycle unless an untaken result stalls
// the input, a rate set by the single compare-and-shift pass through the cells.
// Reset holds entries 0 to 6 (entry i equals i) and a count of seven; the
// result register comes up empty.
// The result register parts the channels: a new word is taken while the
// last result is being taken, and input stalls only while an untaken
// result sits in the register.
`include "ordered_list_append_find_remove_defines.svh"

module ordered_list_append_find_remove (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] position, [8:4] entry_count, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned DEPTH = olafr_pkg::DEPTH;
  localparam int unsigned IDX_W = olafr_pkg::IDX_W;
  localparam int unsigned CNT_W = olafr_pkg::CNT_W;

  logic                                 accept;
  logic                                 full;
  logic                                 found;
  logic [olafr_pkg::REQ_W-1:0]          req;
  olafr_pkg::cell_ctrl_t                ctrl;
  olafr_pkg::link_t                     links [DEPTH];
  logic [DEPTH:0]                       seen;
  logic [DEPTH-1:0]                     first_vec;
  logic [DEPTH-1:0]                     valid_vec;
  logic [IDX_W-1:0]                     pos_idx;
  logic [CNT_W-1:0]                     count_q, count_d;
  logic [olafr_pkg::STATUS_W-1:0]       status_d;
  logic [olafr_pkg::POS_W-1:0]          position_d;
  logic                                 out_valid_q;
  logic [olafr_pkg::STATUS_W-1:0]       out_status_q;
  logic [olafr_pkg::POS_W-1:0]          out_pos_q;
  logic [olafr_pkg::CNT_OUT_W-1:0]      out_cnt_q;

  // Handshake
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = s_axis_tuser;
  assign full          = (count_q == CNT_W'(DEPTH));

  // Request broadcast
  assign ctrl.append = accept && (req == olafr_pkg::REQ_APPEND) && !full;
  assign ctrl.remove = accept && (req == olafr_pkg::REQ_REMOVE);
  assign ctrl.value  = s_axis_tdata;

  // Cell chain
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    olafr_pkg::link_t next_link;
    logic             prev_valid;

    if (i == DEPTH - 1) begin : g_last
      assign next_link = '0;
    end else begin : g_mid
      assign next_link = links[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = links[i-1].valid;
    end

    olafr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .rst_link_i   (olafr_pkg::reset_link(i)),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .seen_i       (seen[i]),
      .next_i       (next_link),
      .link_o       (links[i]),
      .seen_o       (seen[i+1]),
      .first_o      (first_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  assign found = seen[DEPTH];

  // Encode the one-hot first match
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  // Status, position and next count
  always_comb begin
    status_d   = olafr_pkg::ST_OK;
    position_d = '0;
    count_d    = count_q;
    unique case (req)
      olafr_pkg::REQ_APPEND: begin
        if (full) begin
          status_d = olafr_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      olafr_pkg::REQ_FIND: begin
        if (found) begin
          position_d = olafr_pkg::POS_W'(pos_idx);
        end else begin
          status_d = olafr_pkg::ST_NOT_FOUND;
        end
      end
      olafr_pkg::REQ_REMOVE: begin
        if (found) begin
          position_d = olafr_pkg::POS_W'(pos_idx);
          count_d    = count_q - 1'b1;
        end else begin
          status_d = olafr_pkg::ST_NOT_FOUND;
        end
      end
      olafr_pkg::REQ_NOP: begin
        status_d = olafr_pkg::ST_OK;
      end
      default: begin
        status_d = olafr_pkg::ST_OK;
      end
    endcase
  end

  // Entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_W'(olafr_pkg::RESET_FILL);
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_pos_q    <= position_d;
      out_cnt_q    <= olafr_pkg::CNT_OUT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{olafr_pkg::OUT_PAD_W{1'b0}}, out_cnt_q, out_pos_q};

  // Checks
  `OLAFR_ASSERT(a_count_matches_cells, ($countones(valid_vec) == 32'(count_q)), "count disagrees with occupied cells")
  `OLAFR_ASSERT(a_single_first_match, $onehot0(first_vec), "more than one first match in chain")
  `OLAFR_ASSERT(a_remove_shrinks, (accept && (req == olafr_pkg::REQ_REMOVE) && found |=> count_q == $past(count_q) - 1'b1), "remove did not drop the count")
  `OLAFR_ASSERT(a_full_only_at_depth, (out_valid_q && (out_status_q == olafr_pkg::ST_FULL) |-> full), "full status while list not full")

endmodule
